### src/deq_pkg.sv
// Package for the double-ended queue.
// It holds the shared widths, mode and status codes, and the command and status
// structs between the controller and the datapath. It depends on nothing else.
package deq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;

  // Operation codes carried by the mode field of an input word.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  // Datapath operation requested by the controller.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_F,
    DP_PUSH_R,
    DP_POP_F,
    DP_POP_R,
    DP_LIST_FIRST,
    DP_LIST_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic                ld_imm;
    logic [STATUS_W-1:0] imm_status;
    logic                ld_ram;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_last;
  } dp_sts_t;

endpackage

### src/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/deq_ctrl.sv
// Controller state machine of the double-ended queue.
// It decodes input words and steers the datapath; it uses deq_pkg.
module deq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [deq_pkg::MODE_W-1:0]    in_mode,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output deq_pkg::dp_cmd_t              cmd,
  input  deq_pkg::dp_sts_t              sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   listing_r, listing_nxt;
  logic   out_valid_r;
  logic   in_stall_r;

  always_comb begin
    cmd = '{op: deq_pkg::DP_NONE, ld_imm: 1'b0, imm_status: deq_pkg::ST_OK, ld_ram: 1'b0};
    state_nxt   = state_r;
    listing_nxt = listing_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode) inside
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
              listing_nxt = 1'b0;
              state_nxt   = S_SEND;
              cmd.ld_imm  = 1'b1;
              if (sts.full) begin
                cmd.imm_status = deq_pkg::ST_OVER;
              end else begin
                cmd.op = (in_mode == deq_pkg::MODE_PUSH_FRONT) ? deq_pkg::DP_PUSH_F
                                                               : deq_pkg::DP_PUSH_R;
              end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
              listing_nxt = 1'b0;
              if (sts.empty) begin
                cmd.ld_imm     = 1'b1;
                cmd.imm_status = deq_pkg::ST_UNDER;
                state_nxt      = S_SEND;
              end else begin
                cmd.op = (in_mode == deq_pkg::MODE_POP_FRONT) ? deq_pkg::DP_POP_F
                                                              : deq_pkg::DP_POP_R;
                state_nxt = S_READ;
              end
            end
            deq_pkg::MODE_LIST: begin
              if (sts.empty) begin
                listing_nxt    = 1'b0;
                cmd.ld_imm     = 1'b1;
                cmd.imm_status = deq_pkg::ST_UNDER;
                state_nxt      = S_SEND;
              end else begin
                listing_nxt = 1'b1;
                cmd.op      = deq_pkg::DP_LIST_FIRST;
                state_nxt   = S_READ;
              end
            end
            default: begin
              // Unused codes are consumed without any result.
            end
          endcase
        end
      end
      S_READ: begin
        cmd.ld_ram = 1'b1;
        state_nxt  = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          if (listing_r && !sts.out_last) begin
            cmd.op    = deq_pkg::DP_LIST_NEXT;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      listing_r   <= 1'b0;
      out_valid_r <= 1'b0;
      in_stall_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      listing_r   <= listing_nxt;
      out_valid_r <= (state_nxt == S_SEND);
      in_stall_r  <= (state_nxt != S_IDLE);
    end
  end

  assign out_valid = out_valid_r;
  assign in_stall  = in_stall_r;

endmodule

### src/deq_dp.sv
// Datapath of the double-ended queue: circular-buffer pointers, entry RAM and
// the output word register. It uses deq_pkg and instantiates deq_ram.
module deq_dp #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  deq_pkg::dp_cmd_t                    cmd,
  output deq_pkg::dp_sts_t                    sts,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_push_value,
  output logic [deq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [deq_pkg::DATA_W-1:0]   out_data,
  output logic                                out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          last_pend_r, last_pend_nxt;

  logic [deq_pkg::STATUS_W-1:0] out_status_r;
  logic [deq_pkg::DATA_W-1:0]   out_data_r;
  logic                         out_last_r;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [deq_pkg::DATA_W-1:0] ram_rdata;

  logic [AW-1:0] head_m1;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] idx_p1;

  // Position offset steps behind the head, wrapped into the buffer.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign head_m1  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign count_m1 = count_r - CW'(1);
  assign idx_p1   = idx_r + AW'(1);

  always_comb begin
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = head_r;
    ram_raddr     = head_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    last_pend_nxt = last_pend_r;
    case (cmd.op)
      deq_pkg::DP_PUSH_F: begin
        ram_we    = 1'b1;
        ram_waddr = head_m1;
        head_nxt  = head_m1;
        count_nxt = count_r + CW'(1);
      end
      deq_pkg::DP_PUSH_R: begin
        ram_we    = 1'b1;
        ram_waddr = slot(head_r, count_r[AW-1:0]);
        count_nxt = count_r + CW'(1);
      end
      deq_pkg::DP_POP_F: begin
        ram_re        = 1'b1;
        ram_raddr     = head_r;
        head_nxt      = slot(head_r, AW'(1));
        count_nxt     = count_m1;
        last_pend_nxt = 1'b1;
      end
      deq_pkg::DP_POP_R: begin
        ram_re        = 1'b1;
        ram_raddr     = slot(head_r, count_m1[AW-1:0]);
        count_nxt     = count_m1;
        last_pend_nxt = 1'b1;
      end
      deq_pkg::DP_LIST_FIRST: begin
        ram_re        = 1'b1;
        ram_raddr     = head_r;
        idx_nxt       = '0;
        last_pend_nxt = (count_r == CW'(1));
      end
      deq_pkg::DP_LIST_NEXT: begin
        ram_re        = 1'b1;
        ram_raddr     = slot(head_r, idx_p1);
        idx_nxt       = idx_p1;
        last_pend_nxt = (({1'b0, idx_p1} + (AW+1)'(1)) == (AW+1)'(count_r));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      last_pend_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_imm) begin
      out_status_r <= cmd.imm_status;
      out_data_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.ld_ram) begin
      out_status_r <= deq_pkg::ST_OK;
      out_data_r   <= ram_rdata;
      out_last_r   <= last_pend_r;
    end
  end

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.out_last = out_last_r;

  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

### src/double_ended_queue.sv
// Top level of the double-ended queue.
// It joins deq_ctrl and deq_dp and uses the constants of deq_pkg.
//
// The block holds up to DEPTH signed 32-bit values in a circular buffer kept
// in a RAM. Each word on the input channel (in_valid, in_stall, in_mode,
// in_push_value) asks for a push or pop at either end or for a listing of
// the contents. Results leave on the output channel (out_valid, out_stall,
// out_status, out_data, out_last); out_last marks the final result word of
// each input word. Unused mode codes are consumed and give no result.
// One input word is worked on at a time. A push, a failed pop and any
// failed listing present their result in the cycle after acceptance, and
// the block takes the next word only once that result has gone. A good
// pop goes through the registered RAM read, in state S_READ and then
// S_SEND, before its result shows. A listing reads one entry per RAM
// access and passes through S_READ and S_SEND for each entry. All of
// this is held up while the receiver holds out_stall high;
// a result word stays on the outputs unchanged until it is taken, and
// in_stall stays high until the last result word of the current input
// word has gone. Reset empties the queue and leaves the block idle with
// in_stall low; the entry RAM is not cleared, since only written entries
// are ever read.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [deq_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [deq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [deq_pkg::DATA_W-1:0]   out_data,
  output logic                                out_last
);

  // Commands from the controller and status back from the datapath.
  deq_pkg::dp_cmd_t cmd;
  deq_pkg::dp_sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_push_value (in_push_value),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_last      (out_last)
  );

endmodule

### src/deq_chk.sv
// Port-level checker for the double-ended queue, bound to the top level.
// It uses the status and mode codes of deq_pkg.
module deq_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [deq_pkg::MODE_W-1:0]          in_mode,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [deq_pkg::STATUS_W-1:0]        out_status,
  input logic signed [deq_pkg::DATA_W-1:0]   out_data,
  input logic                                out_last
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_data)
                               && $stable(out_last))
    else $error("result word changed while stalled");

  // A word with a meaningful mode occupies the block in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == deq_pkg::MODE_PUSH_FRONT
      || in_mode == deq_pkg::MODE_POP_FRONT || in_mode == deq_pkg::MODE_PUSH_REAR
      || in_mode == deq_pkg::MODE_POP_REAR || in_mode == deq_pkg::MODE_LIST)
    |=> in_stall)
    else $error("block took no time for an operation");

  // Error results are single words with zero data.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == deq_pkg::ST_OVER || out_status == deq_pkg::ST_UNDER)
    |-> out_last && (out_data == '0))
    else $error("malformed error result");

  // No result is offered while the input side is open.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result offered while idle");

endmodule

bind double_ended_queue deq_chk u_deq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_mode    (in_mode),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_data   (out_data),
  .out_last   (out_last)
);

### dv/tb_top.sv
// Self-checking testbench for the double-ended queue (double_ended_queue).
// It depends only on deq_pkg and the block itself. A clocked driver and monitor exchange
// words with the block, and a shadow deque predicts every result word.
module tb_top;

  localparam int DEPTH          = deq_pkg::DEPTH_DEF;
  // Mode codes the block consumes without giving a result.
  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [deq_pkg::MODE_W-1:0] MODE_SPARE_HI  = 3'd7;
  localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [deq_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int RANDOM_WORDS   = 335;   // counted without the ignored codes
  localparam int TAIL_WORDS     = 40;    // the last words go without any idling
  localparam int SQUEEZE_AT     = 150;   // input word count that starts the long hold-off
  localparam int SQUEEZE_CYCLES = 90;
  localparam int DRAIN_TAIL     = 20;    // quiet cycles after the last expected word
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake

  // One word on the input channel, plus a flag that makes the driver wait
  // until every expected result has come before it offers this word.
  typedef struct {
    logic [deq_pkg::MODE_W-1:0]        mode;
    logic signed [deq_pkg::DATA_W-1:0] value;
    logic                              hold;
  } word_t;

  // One word on the result channel.
  typedef struct {
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic signed [deq_pkg::DATA_W-1:0] data;
    logic                              last;
  } reply_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [deq_pkg::MODE_W-1:0]          in_mode = '0;
  logic signed [deq_pkg::DATA_W-1:0]   in_push_value = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [deq_pkg::STATUS_W-1:0]        out_status;
  logic signed [deq_pkg::DATA_W-1:0]   out_data;
  logic                                out_last;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_push_value(in_push_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_last     (out_last)
  );

  // Free-running clock with a period of 20.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow copy of the deque. The front sits at shadow_head and the
  // elements run on from there around the circular buffer.
  logic signed [deq_pkg::DATA_W-1:0] shadow_mem [DEPTH];
  int                                shadow_head = 0;
  int                                shadow_fill = 0;

  word_t  pending[$];       // words still to be offered
  word_t  cur;              // word now on the input ports
  reply_t replies_due[$];   // predicted result words, oldest first
  reply_t want_r;

  int   total_words   = 0;  // words the stimulus holds, ignored codes included
  int   words_sent    = 0;  // input words accepted so far
  int   replies_owed  = 0;  // result words predicted so far
  int   replies_taken = 0;  // result words accepted so far; written by the monitor only
  int   mismatches    = 0;
  int   quiet_cycles  = 0;

  // Driver state. The flags below are written with nonblocking assignments
  // so that the receiver reads them without depending on event order.
  int   gap_left  = 0;
  int   calm_left = 0;
  logic tail_phase  = 1'b0;
  logic squeeze_req = 1'b0;

  // Receiver state.
  int   burst_left   = 0;
  int   rx_calm_left = 0;
  int   squeeze_left = 0;
  logic squeeze_done = 1'b0;

  function automatic void add_reply(input logic [deq_pkg::STATUS_W-1:0] status,
                                    input logic signed [deq_pkg::DATA_W-1:0] data,
                                    input logic last);
    reply_t r;
    r.status = status;
    r.data   = data;
    r.last   = last;
    replies_due.push_back(r);
    replies_owed++;
  endfunction

  // Applies one accepted input word to the shadow deque and queues the
  // result words it must cause.
  function automatic void deque_apply(input word_t w);
    int k;
    case (w.mode)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
        if (shadow_fill >= DEPTH) begin
          // A push into a full deque changes nothing and reports overflow.
          add_reply(deq_pkg::ST_OVER, '0, 1'b1);
        end else begin
          if (w.mode == deq_pkg::MODE_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            shadow_mem[shadow_head] = w.value;
          end else begin
            shadow_mem[(shadow_head + shadow_fill) % DEPTH] = w.value;
          end
          shadow_fill++;
          add_reply(deq_pkg::ST_OK, '0, 1'b1);
        end
      end
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR: begin
        if (shadow_fill == 0) begin
          add_reply(deq_pkg::ST_UNDER, '0, 1'b1);
        end else if (w.mode == deq_pkg::MODE_POP_FRONT) begin
          add_reply(deq_pkg::ST_OK, shadow_mem[shadow_head], 1'b1);
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end else begin
          // A pop from the rear leaves the head where it is, even when
          // the deque drains.
          add_reply(deq_pkg::ST_OK,
                    shadow_mem[(shadow_head + shadow_fill - 1) % DEPTH], 1'b1);
          shadow_fill--;
        end
      end
      deq_pkg::MODE_LIST: begin
        if (shadow_fill == 0) begin
          add_reply(deq_pkg::ST_UNDER, '0, 1'b1);
        end else begin
          for (k = 0; k < shadow_fill; k++) begin
            add_reply(deq_pkg::ST_OK, shadow_mem[(shadow_head + k) % DEPTH],
                      k == shadow_fill - 1);
          end
        end
      end
      default: begin
        // The spare codes are taken in and give nothing.
      end
    endcase
  endfunction

  function automatic void add_word(input logic [deq_pkg::MODE_W-1:0] mode,
                                   input logic signed [deq_pkg::DATA_W-1:0] value,
                                   input logic hold);
    word_t w;
    w.mode  = mode;
    w.value = value;
    w.hold  = hold;
    pending.push_back(w);
  endfunction

  // Mostly uniform 32-bit values, with the extremes mixed in now and then.
  function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
    logic signed [deq_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = VAL_MAX;
      1:       v = VAL_MIN;
      2:       v = '0;
      3:       v = -1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Driver. The word on the ports stays put while in_stall is high; a new
  // word, or an idle cycle, is chosen only once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deque_apply(cur);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() <= TAIL_WORDS) tail_phase <= 1'b1;
        if (words_sent >= SQUEEZE_AT) squeeze_req <= 1'b1;
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending[0].hold && replies_taken != replies_owed) begin
          // Pause here until the block has handed over every result.
          in_valid <= 1'b0;
        end else begin
          cur = pending.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= cur.mode;
          in_push_value <= cur.value;
          // Decide whether an idle burst follows this word.
          if (tail_phase) begin
            gap_left = 0;
          end else if (calm_left > 0) begin
            calm_left--;
          end else if ($urandom_range(0, 2) == 0) begin
            gap_left = $urandom_range(1, 13);
          end else begin
            calm_left = $urandom_range(0, 25);
          end
        end
      end
    end
  end

  // Receiver. It stalls in random bursts, once holds off for a long stretch
  // so that the block backs up into in_stall, and stays open at the end.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (squeeze_left > 0) begin
      squeeze_left--;
      out_stall <= 1'b1;
    end else if (squeeze_req && !squeeze_done) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (tail_phase) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (rx_calm_left > 0) begin
      rx_calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      burst_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      rx_calm_left = $urandom_range(0, 30);
      out_stall <= 1'b0;
    end
  end

  // Monitor. Every accepted result word is checked against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      replies_taken <= replies_taken + 1;
      if (replies_due.size() == 0) begin
        $error("result word with no expectation: status %0d data %0d last %0d",
               out_status, out_data, out_last);
        mismatches++;
      end else begin
        want_r = replies_due.pop_front();
        if (out_status !== want_r.status) begin
          $error("out_status: expected %0d, actual %0d", want_r.status, out_status);
          mismatches++;
        end
        if (out_data !== want_r.data) begin
          $error("out_data: expected %0d, actual %0d", want_r.data, out_data);
          mismatches++;
        end
        if (out_last !== want_r.last) begin
          $error("out_last: expected %0d, actual %0d", want_r.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either channel means the
  // block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n;
    int bias;
    int pick;
    int unsigned spare;
    logic [deq_pkg::MODE_W-1:0] m;

    // Directed words. The deque starts empty, so every read fails first.
    add_word(deq_pkg::MODE_LIST,      '0, 1'b0);
    add_word(deq_pkg::MODE_POP_FRONT, '0, 1'b0);
    add_word(deq_pkg::MODE_POP_REAR,  -1, 1'b0);
    // The first front push wraps the head below zero.
    add_word(deq_pkg::MODE_PUSH_FRONT, VAL_MAX, 1'b0);
    add_word(deq_pkg::MODE_PUSH_REAR,  VAL_MIN, 1'b0);
    add_word(deq_pkg::MODE_PUSH_FRONT, '0, 1'b0);
    add_word(deq_pkg::MODE_PUSH_REAR,  -1, 1'b0);
    // Spare codes must be swallowed without any result.
    add_word(MODE_SPARE_LO,  VAL_MAX, 1'b0);
    add_word(MODE_SPARE_MID, VAL_MIN, 1'b0);
    add_word(MODE_SPARE_HI,  -1, 1'b0);
    // Fill up, then push into a full deque at both ends.
    add_word(deq_pkg::MODE_PUSH_FRONT, 32'sh5555_5555, 1'b0);
    add_word(deq_pkg::MODE_PUSH_REAR,  32'shAAAA_AAAA, 1'b0);
    add_word(deq_pkg::MODE_PUSH_FRONT, 32'sh0000_0001, 1'b0);
    add_word(deq_pkg::MODE_PUSH_REAR,  32'sh1234_5678, 1'b0);
    add_word(deq_pkg::MODE_PUSH_FRONT, VAL_MIN, 1'b0);
    add_word(deq_pkg::MODE_PUSH_REAR,  VAL_MAX, 1'b0);
    // A listing of a full deque gives the longest burst of results.
    add_word(deq_pkg::MODE_LIST, '0, 1'b0);
    // Drain it from both ends until it is empty again.
    for (n = 0; n < DEPTH; n++) begin
      add_word((n % 2) ? deq_pkg::MODE_POP_REAR : deq_pkg::MODE_POP_FRONT, '0, 1'b0);
    end
    add_word(deq_pkg::MODE_LIST, '0, 1'b0);

    // Random words in runs that lean toward filling, draining or neither,
    // so that the full and the empty deque both come up often.
    n = 0;
    bias = 0;
    while (n < RANDOM_WORDS) begin
      if (n % 24 == 0) bias = $urandom_range(0, 2);
      if ($urandom_range(0, 24) == 0) begin
        spare = $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);
        add_word(spare[deq_pkg::MODE_W-1:0], pick_value(), 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < ((bias == 0) ? 60 : (bias == 1) ? 25 : 45)) begin
          m = $urandom_range(0, 1) ? deq_pkg::MODE_PUSH_REAR : deq_pkg::MODE_PUSH_FRONT;
        end else if (pick < 89) begin
          m = $urandom_range(0, 1) ? deq_pkg::MODE_POP_REAR : deq_pkg::MODE_POP_FRONT;
        end else begin
          m = deq_pkg::MODE_LIST;
        end
        // The first random word, and a few later ones, wait for a full drain.
        add_word(m, pick_value(), (n == 0) || ($urandom_range(0, 39) == 0));
        n++;
      end
    end
    total_words = pending.size();

    // Synchronous reset, then let the driver run.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (words_sent == total_words);
    while (replies_taken != replies_owed) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d expected result words never arrived", replies_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue.sv
src/deq_chk.sv
dv/tb_top.sv
